@@ sv/lsga_pkg.sv @@
// ----------------------------------------------------------------------------
// lsga_pkg
// Types, constants and arithmetic helpers shared by the lens shading gain
// apply block and its RAM.
// ----------------------------------------------------------------------------
package lsga_pkg;

	localparam int GRID_COLUMNS_DEF = 16;
	localparam int GRID_ROWS_DEF    = 16;
	localparam int GAIN_DEPTH       = 256;
	localparam int GAIN_W           = 16;
	localparam int COORD_W          = 12;
	localparam int SAMPLE_W         = 8;
	localparam int CFG_INDEX_W      = 4;
	localparam int CFG_DATA_W       = 12;
	localparam logic [COORD_W-1:0] BLOCK_SIZE_RESET = 12'd64;
	localparam logic [COORD_W-1:0] BLOCK_SIZE_MIN   = 12'd2;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BLOCK_WIDTH  = 4'd0,
		CFG_BLOCK_HEIGHT = 4'd1
	} cfg_index_t;

	typedef struct packed {
		op_t                 op;
		logic [7:0]          gain_index;
		logic [GAIN_W-1:0]   gain_value;
		logic [COORD_W-1:0]  pixel_x;
		logic [COORD_W-1:0]  pixel_y;
		logic [SAMPLE_W-1:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] corrected_value;
		logic                saturated;
	} out_item_t;

	// sideband that rides along the whole pipeline
	typedef struct packed {
		op_t                 op;
		logic [7:0]          gain_index;
		logic [GAIN_W-1:0]   gain_value;
		logic [SAMPLE_W-1:0] pixel_value;
	} side_t;

	// One restoring step of pos / size: returns {quotient bit, remainder}.
	function automatic logic [COORD_W:0] cell_div_step(
		input logic [COORD_W-1:0] rem,
		input logic               nbit,
		input logic [COORD_W-1:0] size
	);
		logic [COORD_W:0] r;
		logic [COORD_W:0] d;
		r = {rem, nbit};
		d = {1'b0, size};
		if (r >= d) begin
			r = r - d;
			return {1'b1, r[COORD_W-1:0]};
		end
		return {1'b0, r[COORD_W-1:0]};
	endfunction

	// One step of the weight fraction num * 2^16 / den, num < den.
	function automatic logic [COORD_W+1:0] weight_div_step(
		input logic [COORD_W:0] rem,
		input logic [COORD_W:0] den
	);
		logic [COORD_W+1:0] r;
		logic [COORD_W+1:0] d;
		r = {rem, 1'b0};
		d = {1'b0, den};
		if (r >= d) begin
			r = r - d;
			return {1'b1, r[COORD_W:0]};
		end
		return {1'b0, r[COORD_W:0]};
	endfunction

endpackage

@@ sv/lsga_ram.sv @@
// ----------------------------------------------------------------------------
// lsga_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsga_ram #(
	parameter int WIDTH = lsga_pkg::GAIN_W,
	parameter int DEPTH = lsga_pkg::GAIN_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/lens_shading_gain_apply.sv @@
// ----------------------------------------------------------------------------
// lens_shading_gain_apply
// Bilinear lens shading gain correction of one color channel.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output is not stalled, gain
// writes and pixels mixed in any order, and returns one result per pixel;
// gain writes produce no result. The pipeline is a 12-stage pipelined
// divider that finds the grid cell and a 16-stage pipelined divider that
// forms the Q0.16 interpolation weights, followed by the gain RAM read and
// five multiply and add stages. The gain grid lives in four identical RAM
// copies, one per neighbor gain, written together; it has no clearing pass
// and must be loaded before pixels that use it. Write block_width and
// block_height only while the pipeline is empty. A stalled output holds the
// whole pipeline.
module lens_shading_gain_apply #(
	parameter int GRID_COLUMNS = lsga_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = lsga_pkg::GRID_ROWS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  lsga_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output lsga_pkg::out_item_t                   out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lsga_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lsga_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CW    = lsga_pkg::COORD_W;
	localparam int GW    = lsga_pkg::GAIN_W;
	localparam int COLW  = $clog2(GRID_COLUMNS);
	localparam int ROWW  = $clog2(GRID_ROWS);
	localparam int AW    = $clog2(lsga_pkg::GAIN_DEPTH);
	localparam int D1    = CW;          // cell divider steps
	localparam int D2    = GW;          // weight divider steps
	localparam int S_B   = D1 + 1;      // stage that forms weights inputs
	localparam int S_R   = S_B + D2 + 1; // RAM data stage
	localparam int S_END = S_R + 5;     // last arithmetic stage

	// ---------------- configuration ----------------
	logic [CW-1:0] block_width_q, block_height_q;
	logic [CW-1:0] bw, bh;
	logic [CW:0]   den_x, den_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_width_q  <= lsga_pkg::BLOCK_SIZE_RESET;
			block_height_q <= lsga_pkg::BLOCK_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsga_pkg::CFG_BLOCK_WIDTH:  block_width_q  <= cfg_data;
				lsga_pkg::CFG_BLOCK_HEIGHT: block_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bw    = (block_width_q < lsga_pkg::BLOCK_SIZE_MIN) ?
		lsga_pkg::BLOCK_SIZE_MIN : block_width_q;
	assign bh    = (block_height_q < lsga_pkg::BLOCK_SIZE_MIN) ?
		lsga_pkg::BLOCK_SIZE_MIN : block_height_q;
	assign den_x = {bw, 1'b0};
	assign den_y = {bh, 1'b0};

	// ---------------- pipeline control ----------------
	logic                 en;
	logic                 out_valid_q;
	logic                 valid_s [S_END+1];
	lsga_pkg::side_t      side_s  [S_END+1];

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= S_END; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int k = 1; k <= S_END; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= '{op: in_data.op, gain_index: in_data.gain_index,
				gain_value: in_data.gain_value, pixel_value: in_data.pixel_value};
			for (int k = 1; k <= S_END; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------- cell divider: pos / block size ----------------
	logic [CW-1:0] d1_x_s [D1+1];
	logic [CW-1:0] d1_y_s [D1+1];
	logic [CW-1:0] d1_xr_s [D1+1];
	logic [CW-1:0] d1_yr_s [D1+1];
	logic [CW-1:0] d1_xq_s [D1+1];
	logic [CW-1:0] d1_yq_s [D1+1];

	always_ff @(posedge clk) begin
		if (en) begin
			d1_x_s[0]  <= in_data.pixel_x;
			d1_y_s[0]  <= in_data.pixel_y;
			d1_xr_s[0] <= '0;
			d1_yr_s[0] <= '0;
			d1_xq_s[0] <= '0;
			d1_yq_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= D1; k++) begin : g_cell_div
		logic [CW:0] sx, sy;
		assign sx = lsga_pkg::cell_div_step(d1_xr_s[k-1], d1_x_s[k-1][D1-k], bw);
		assign sy = lsga_pkg::cell_div_step(d1_yr_s[k-1], d1_y_s[k-1][D1-k], bh);
		always_ff @(posedge clk) begin
			if (en) begin
				d1_x_s[k]  <= d1_x_s[k-1];
				d1_y_s[k]  <= d1_y_s[k-1];
				d1_xr_s[k] <= sx[CW-1:0];
				d1_yr_s[k] <= sy[CW-1:0];
				d1_xq_s[k] <= {d1_xq_s[k-1][CW-2:0], sx[CW]};
				d1_yq_s[k] <= {d1_yq_s[k-1][CW-2:0], sy[CW]};
			end
		end
	end

	// ---------------- neighbor cells and weight numerators ----------------
	logic [CW-1:0] cx, cy, offx, offy;
	logic          left, top_half, outside;
	logic [CW:0]   numx, numy;
	logic [CW-1:0] c0_w, c1_w, r0_w, r1_w;

	assign cx       = d1_xq_s[D1];
	assign cy       = d1_yq_s[D1];
	assign offx     = d1_xr_s[D1];
	assign offy     = d1_yr_s[D1];
	assign outside  = (cx >= CW'(GRID_COLUMNS)) || (cy >= CW'(GRID_ROWS));
	assign left     = {offx, 1'b0} < {1'b0, bw};
	assign top_half = {offy, 1'b0} < {1'b0, bh};
	assign numx     = left ? ({1'b0, bw} + {offx, 1'b0}) : ({offx, 1'b0} - {1'b0, bw});
	assign numy     = top_half ? ({1'b0, bh} + {offy, 1'b0}) :
		({offy, 1'b0} - {1'b0, bh});

	// clamp neighbor indices at the grid edges
	always_comb begin
		if (left) begin
			c0_w = (cx == '0) ? '0 : cx - 1'b1;
			c1_w = cx;
		end else begin
			c0_w = cx;
			c1_w = (cx + 1'b1 >= CW'(GRID_COLUMNS)) ? CW'(GRID_COLUMNS - 1) : cx + 1'b1;
		end
		if (top_half) begin
			r0_w = (cy == '0) ? '0 : cy - 1'b1;
			r1_w = cy;
		end else begin
			r0_w = cy;
			r1_w = (cy + 1'b1 >= CW'(GRID_ROWS)) ? CW'(GRID_ROWS - 1) : cy + 1'b1;
		end
	end

	// ---------------- weight divider: num * 2^16 / (2 * size) ----------------
	logic [CW:0]   d2_xr_s [D2+1];
	logic [CW:0]   d2_yr_s [D2+1];
	logic [GW-1:0] d2_xq_s [D2+1];
	logic [GW-1:0] d2_yq_s [D2+1];
	logic [COLW-1:0] c0_s [D2+1];
	logic [COLW-1:0] c1_s [D2+1];
	logic [ROWW-1:0] r0_s [D2+1];
	logic [ROWW-1:0] r1_s [D2+1];
	logic            outside_s [D2+1];

	always_ff @(posedge clk) begin
		if (en) begin
			d2_xr_s[0]   <= numx;
			d2_yr_s[0]   <= numy;
			d2_xq_s[0]   <= '0;
			d2_yq_s[0]   <= '0;
			c0_s[0]      <= c0_w[COLW-1:0];
			c1_s[0]      <= c1_w[COLW-1:0];
			r0_s[0]      <= r0_w[ROWW-1:0];
			r1_s[0]      <= r1_w[ROWW-1:0];
			outside_s[0] <= outside;
		end
	end

	for (genvar k = 1; k <= D2; k++) begin : g_weight_div
		logic [CW+1:0] sx, sy;
		assign sx = lsga_pkg::weight_div_step(d2_xr_s[k-1], den_x);
		assign sy = lsga_pkg::weight_div_step(d2_yr_s[k-1], den_y);
		always_ff @(posedge clk) begin
			if (en) begin
				d2_xr_s[k]   <= sx[CW:0];
				d2_yr_s[k]   <= sy[CW:0];
				d2_xq_s[k]   <= {d2_xq_s[k-1][GW-2:0], sx[CW+1]};
				d2_yq_s[k]   <= {d2_yq_s[k-1][GW-2:0], sy[CW+1]};
				c0_s[k]      <= c0_s[k-1];
				c1_s[k]      <= c1_s[k-1];
				r0_s[k]      <= r0_s[k-1];
				r1_s[k]      <= r1_s[k-1];
				outside_s[k] <= outside_s[k-1];
			end
		end
	end

	// ---------------- gain RAM copies ----------------
	logic [15:0]   a00, a01, a10, a11;
	logic          gain_we;
	logic [GW-1:0] g00, g01, g10, g11;

	assign a00 = 16'(r0_s[D2]) * 16'(GRID_COLUMNS) + 16'(c0_s[D2]);
	assign a01 = 16'(r0_s[D2]) * 16'(GRID_COLUMNS) + 16'(c1_s[D2]);
	assign a10 = 16'(r1_s[D2]) * 16'(GRID_COLUMNS) + 16'(c0_s[D2]);
	assign a11 = 16'(r1_s[D2]) * 16'(GRID_COLUMNS) + 16'(c1_s[D2]);
	// commit writes where pixels read, so later pixels see them in order
	assign gain_we = en && valid_s[S_R-1] && (side_s[S_R-1].op == lsga_pkg::OP_WRITE);

	lsga_ram #(.WIDTH(GW), .DEPTH(lsga_pkg::GAIN_DEPTH)) u_ram00 (
		.clk(clk), .we(gain_we), .waddr(side_s[S_R-1].gain_index[AW-1:0]),
		.wdata(side_s[S_R-1].gain_value), .re(en), .raddr(a00[AW-1:0]), .rdata(g00));
	lsga_ram #(.WIDTH(GW), .DEPTH(lsga_pkg::GAIN_DEPTH)) u_ram01 (
		.clk(clk), .we(gain_we), .waddr(side_s[S_R-1].gain_index[AW-1:0]),
		.wdata(side_s[S_R-1].gain_value), .re(en), .raddr(a01[AW-1:0]), .rdata(g01));
	lsga_ram #(.WIDTH(GW), .DEPTH(lsga_pkg::GAIN_DEPTH)) u_ram10 (
		.clk(clk), .we(gain_we), .waddr(side_s[S_R-1].gain_index[AW-1:0]),
		.wdata(side_s[S_R-1].gain_value), .re(en), .raddr(a10[AW-1:0]), .rdata(g10));
	lsga_ram #(.WIDTH(GW), .DEPTH(lsga_pkg::GAIN_DEPTH)) u_ram11 (
		.clk(clk), .we(gain_we), .waddr(side_s[S_R-1].gain_index[AW-1:0]),
		.wdata(side_s[S_R-1].gain_value), .re(en), .raddr(a11[AW-1:0]), .rdata(g11));

	// ---------------- interpolation and gain ----------------
	logic [GW-1:0] wx_sr, wy_sr;
	logic          outside_sr;
	logic [GW:0]   wx_inv, wy_inv;
	logic [32:0]   p00_s1, p01_s1, p10_s1, p11_s1;
	logic [GW-1:0] wy_s1, wy_s2;
	logic          outside_s1, outside_s2, outside_s3, outside_s4, outside_s5;
	logic [33:0]   top_sum, bot_sum, g_sum;
	logic [GW-1:0] top_s2, bot_s2;
	logic [32:0]   ty_s3, by_s3;
	logic [GW-1:0] gain_s4;
	logic [23:0]   prod_s5;
	logic          sat;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_sr      <= d2_xq_s[D2];
			wy_sr      <= d2_yq_s[D2];
			outside_sr <= outside_s[D2];
		end
	end

	assign wx_inv = 17'h10000 - {1'b0, wx_sr};
	assign wy_inv = 17'h10000 - {1'b0, wy_s2};
	assign top_sum = {1'b0, p00_s1} + {1'b0, p01_s1};
	assign bot_sum = {1'b0, p10_s1} + {1'b0, p11_s1};
	assign g_sum   = {1'b0, ty_s3} + {1'b0, by_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1     <= g00 * wx_inv;
			p01_s1     <= g01 * {1'b0, wx_sr};
			p10_s1     <= g10 * wx_inv;
			p11_s1     <= g11 * {1'b0, wx_sr};
			wy_s1      <= wy_sr;
			outside_s1 <= outside_sr;

			top_s2     <= top_sum[31:16];
			bot_s2     <= bot_sum[31:16];
			wy_s2      <= wy_s1;
			outside_s2 <= outside_s1;

			ty_s3      <= top_s2 * wy_inv;
			by_s3      <= bot_s2 * {1'b0, wy_s2};
			outside_s3 <= outside_s2;

			gain_s4    <= g_sum[31:16];
			outside_s4 <= outside_s3;

			prod_s5    <= side_s[S_END-1].pixel_value * gain_s4;
			outside_s5 <= outside_s4;
		end
	end

	// ---------------- output register ----------------
	assign sat = prod_s5 > 24'h0FF000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s[S_END] && (side_s[S_END].op == lsga_pkg::OP_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (outside_s5) begin
				out_data.corrected_value <= side_s[S_END].pixel_value;
				out_data.saturated       <= 1'b0;
			end else if (sat) begin
				out_data.corrected_value <= 8'hFF;
				out_data.saturated       <= 1'b1;
			end else begin
				out_data.corrected_value <= prod_s5[19:12];
				out_data.saturated       <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- assertions ----------------
	a_sat_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.corrected_value == 8'hFF)
		else $error("saturated result not clamped");

	a_neighbors_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[S_B-1] && !outside |-> (c1_w - c0_w <= 1) && (r1_w - r0_w <= 1))
		else $error("neighbor cells not adjacent");

	a_weight_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[S_R-1] |-> (d2_xr_s[D2] < den_x) && (d2_yr_s[D2] < den_y))
		else $error("weight divider remainder out of range");

endmodule
